FILE: rtl/gqg_pkg.sv
package gqg_pkg;

	// metric word positions inside one glyph record
	localparam logic [2:0] M_LEFT   = 3'd0;
	localparam logic [2:0] M_TOP    = 3'd1;
	localparam logic [2:0] M_WIDTH  = 3'd2;
	localparam logic [2:0] M_HEIGHT = 3'd3;
	localparam logic [2:0] M_ADV_X  = 3'd4;
	localparam logic [2:0] M_ADV_Y  = 3'd5;
	localparam logic [2:0] M_U      = 3'd6;
	localparam logic [2:0] M_V      = 3'd7;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_CHAR  = 1'b1;

	localparam logic REG_ATLAS_W = 1'b0;
	localparam logic REG_ATLAS_H = 1'b1;

	localparam int ATLAS_W_BITS = 13;
	localparam logic [ATLAS_W_BITS-1:0] ATLAS_RESET = 13'd256;

	// request to the divider
	typedef struct packed {
		logic                           go;
		logic signed [31:0]             dividend;
		logic [ATLAS_W_BITS-1:0]        divisor;
	} div_req_t;

	// answer from the divider
	typedef struct packed {
		logic                           done;
		logic signed [31:0]             quotient;
	} div_rsp_t;

	// clamp a wide signed value to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sh0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -48'sh0000_8000_0000)
			r = -32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// saturating signed 32-bit add or subtract
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic sub);
		logic signed [32:0] s;
		if (sub)
			s = 33'(a) - 33'(b);
		else
			s = 33'(a) + 33'(b);
		return sat32(48'(s));
	endfunction

endpackage

FILE: rtl/glyph_quad_generator.sv
// glyph quad generator: glyph metric table in one synchronous ram, pen in registers
// metric write: taken while idle, busy stays low, no result word
// character: eight metric reads, six scale multiplies in two phases each, two sum steps;
// that ends an empty glyph or gives the one overflow word, which follows right after;
// a drawn glyph adds two extent divisions, a texture step and six vertex words,
// one per cycle; results strobe once, reset clears pen, count and flag, sets atlas to 256
module glyph_quad_generator #(
	parameter int GLYPH_COUNT  = 256,
	parameter int MAX_VERTICES = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                func,
	input  logic [7:0]                          code,
	input  logic [2:0]                          metric_select,
	input  logic signed [31:0]                  metric_value,
	input  logic                                first_char,
	input  logic signed [31:0]                  start_x,
	input  logic signed [31:0]                  start_y,
	input  logic signed [31:0]                  start_z,
	input  logic [30:0]                         scale_x,
	input  logic [30:0]                         scale_y,
	input  logic                                wr_en,
	input  logic                                wr_index,
	input  logic [gqg_pkg::ATLAS_W_BITS-1:0]    wr_data,
	output logic                                result_valid,
	output logic signed [31:0]                  vert_x,
	output logic signed [31:0]                  vert_y,
	output logic signed [31:0]                  vert_z,
	output logic signed [31:0]                  tex_u,
	output logic signed [31:0]                  tex_v,
	output logic [8:0]                          vertex_number,
	output logic                                overflow,
	output logic                                last_of_quad
);
	import gqg_pkg::*;

	localparam int IDX_W  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam int ADDR_W = IDX_W + 3;
	localparam int DEPTH  = GLYPH_COUNT * 8;
	localparam int CNT_W  = $clog2(MAX_VERTICES + 7);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_MUL, S_SUM1, S_SUM2, S_DIV, S_TEX, S_EMIT
	} state_t;

	state_t                  state_q;
	logic [3:0]              k_q;
	logic [2:0]              m_q;
	logic                    ph_q;
	logic                    div_h_q;
	logic [2:0]              e_q;

	logic [IDX_W-1:0]        idx_q;
	logic                    in_rng_q;
	logic signed [31:0]      z_q;
	logic [30:0]             scx_q;
	logic [30:0]             scy_q;

	logic signed [31:0]      mem [DEPTH];
	logic signed [31:0]      rd_q;
	logic [ADDR_W-1:0]       rd_addr;

	logic signed [31:0]      g_q  [8];
	logic signed [31:0]      sc_q [6];
	logic signed [63:0]      prod_q;
	logic signed [63:0]      prod_rnd;

	logic signed [31:0]      pen_x_q, pen_y_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    ovf_q;
	logic [ATLAS_W_BITS-1:0] atlas_w_q, atlas_h_q;

	logic signed [31:0]      xl_q, xr_q, yt_q, yb_q, u1_q, v1_q, ext_w_q;
	logic                    in_range;

	div_req_t                dreq;
	div_rsp_t                drsp;
	logic                    div_go_q;

	assign in_range = {1'b0, code} < 9'(GLYPH_COUNT);
	assign rd_addr  = {idx_q, k_q[2:0]};
	assign prod_rnd = prod_q + 64'sh8000;
	assign busy     = state_q != S_IDLE;

	// glyph table, one write port, one registered read port
	always_ff @(posedge clk) begin
		if (start && !busy && func == FUNC_WRITE && in_range)
			mem[{code[IDX_W-1:0], metric_select}] <= metric_value;
		rd_q <= mem[rd_addr];
	end

	// atlas registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_w_q <= ATLAS_RESET;
			atlas_h_q <= ATLAS_RESET;
		end else if (wr_en) begin
			if (wr_index == REG_ATLAS_W)
				atlas_w_q <= wr_data;
			else
				atlas_h_q <= wr_data;
		end
	end

	// extent divider, width first then height
	assign dreq.go       = div_go_q;
	assign dreq.dividend = div_h_q ? g_q[M_HEIGHT] : g_q[M_WIDTH];
	assign dreq.divisor  = div_h_q ? atlas_h_q : atlas_w_q;

	gqg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// sequencer with pen, count and result word registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			k_q          <= '0;
			m_q          <= '0;
			ph_q         <= 1'b0;
			div_h_q      <= 1'b0;
			div_go_q     <= 1'b0;
			e_q          <= '0;
			pen_x_q      <= '0;
			pen_y_q      <= '0;
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			div_go_q     <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && func == FUNC_CHAR) begin
						idx_q    <= code[IDX_W-1:0];
						in_rng_q <= in_range;
						z_q      <= start_z;
						scx_q    <= scale_x;
						scy_q    <= scale_y;
						k_q      <= '0;
						if (first_char) begin
							pen_x_q <= start_x;
							pen_y_q <= start_y;
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
						end
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// data of the previous address arrives here
					if (k_q != 4'd0)
						g_q[k_q[2:0] - 3'd1] <= in_rng_q ? rd_q : 32'sd0;
					k_q <= k_q + 4'd1;
					if (k_q == 4'd8) begin
						m_q     <= '0;
						ph_q    <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					// even metrics scale by x, odd by y
					if (!ph_q) begin
						prod_q <= g_q[m_q] * $signed({1'b0, m_q[0] ? scy_q : scx_q});
					end else begin
						sc_q[m_q] <= sat32(prod_rnd[63:16]);
						m_q       <= m_q + 3'd1;
						if (m_q == 3'd5)
							state_q <= S_SUM1;
					end
					ph_q <= !ph_q;
				end
				S_SUM1: begin
					xl_q    <= sat_add(pen_x_q, sc_q[M_LEFT], 1'b0);
					yt_q    <= sat_add(pen_y_q, sc_q[M_TOP], 1'b0);
					pen_x_q <= sat_add(pen_x_q, sc_q[M_ADV_X], 1'b0);
					pen_y_q <= sat_add(pen_y_q, sc_q[M_ADV_Y], 1'b0);
					state_q <= S_SUM2;
				end
				S_SUM2: begin
					xr_q <= sat_add(xl_q, sc_q[M_WIDTH], 1'b0);
					yb_q <= sat_add(yt_q, sc_q[M_HEIGHT], 1'b1);
					if (sc_q[M_WIDTH] == 32'sd0 || sc_q[M_HEIGHT] == 32'sd0) begin
						state_q <= S_IDLE;
					end else if (32'(cnt_q) + 32'd6 > 32'(MAX_VERTICES)) begin
						// buffer full: one flagged word, quad dropped
						ovf_q         <= 1'b1;
						result_valid  <= 1'b1;
						vert_x        <= '0;
						vert_y        <= '0;
						vert_z        <= '0;
						tex_u         <= '0;
						tex_v         <= '0;
						vertex_number <= 9'(cnt_q);
						overflow      <= 1'b1;
						last_of_quad  <= 1'b0;
						state_q       <= S_IDLE;
					end else begin
						div_h_q  <= 1'b0;
						div_go_q <= 1'b1;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (drsp.done) begin
						if (!div_h_q) begin
							ext_w_q  <= drsp.quotient;
							div_h_q  <= 1'b1;
							div_go_q <= 1'b1;
						end else begin
							v1_q    <= sat_add(g_q[M_V], drsp.quotient, 1'b0);
							state_q <= S_TEX;
						end
					end
				end
				S_TEX: begin
					u1_q    <= sat_add(g_q[M_U], ext_w_q, 1'b0);
					e_q     <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// corner order: lt rt lb rt lb rb
					result_valid  <= 1'b1;
					vert_x        <= e_q[0] ? xr_q : xl_q;
					tex_u         <= e_q[0] ? u1_q : g_q[M_U];
					vert_y        <= (e_q == 3'd2 || e_q >= 3'd4) ? yb_q : yt_q;
					tex_v         <= (e_q == 3'd2 || e_q >= 3'd4) ? v1_q : g_q[M_V];
					vert_z        <= z_q;
					vertex_number <= 9'(cnt_q + CNT_W'(1));
					overflow      <= ovf_q;
					last_of_quad  <= e_q == 3'd5;
					cnt_q         <= cnt_q + CNT_W'(1);
					e_q           <= e_q + 3'd1;
					if (e_q == 3'd5)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/gqg_divider.sv
module gqg_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  gqg_pkg::div_req_t req,
	output gqg_pkg::div_rsp_t rsp
);
	import gqg_pkg::*;

	logic                    run_q;
	logic [4:0]              cnt_q;
	logic                    neg_q;
	logic [31:0]             quo_q;
	logic [ATLAS_W_BITS-1:0] rem_q;
	logic [ATLAS_W_BITS-1:0] dvs_q;
	logic                    done_q;
	logic [ATLAS_W_BITS:0]   trial;
	logic                    fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: magnitude in, sign fixed at the end
	always_ff @(posedge clk) begin
		if (req.go) begin
			neg_q <= req.dividend[31];
			quo_q <= req.dividend[31] ? 32'(-req.dividend) : req.dividend;
			rem_q <= '0;
			dvs_q <= (req.divisor == '0) ? ATLAS_W_BITS'(1) : req.divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[30:0], fits};
			rem_q <= fits ? ATLAS_W_BITS'(trial - {1'b0, dvs_q})
			              : trial[ATLAS_W_BITS-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: dv/quad_checker.sv
`timescale 1ns / 100ps

module quad_checker #(
	parameter int GLYPHS    = 256,
	parameter int VERT_LIMIT = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic                           func,
	input  logic [7:0]                     code,
	input  logic [2:0]                     metric_select,
	input  logic signed [31:0]             metric_value,
	input  logic                           first_char,
	input  logic signed [31:0]             start_x,
	input  logic signed [31:0]             start_y,
	input  logic signed [31:0]             start_z,
	input  logic [30:0]                    scale_x,
	input  logic [30:0]                    scale_y,
	input  logic                           wr_en,
	input  logic                           wr_index,
	input  logic [gqg_pkg::ATLAS_W_BITS-1:0] wr_data,
	input  logic                           result_valid,
	input  logic signed [31:0]             vert_x,
	input  logic signed [31:0]             vert_y,
	input  logic signed [31:0]             vert_z,
	input  logic signed [31:0]             tex_u,
	input  logic signed [31:0]             tex_v,
	input  logic [8:0]                     vertex_number,
	input  logic                           overflow,
	input  logic                           last_of_quad,
	output int                             fail_count,
	output int                             pending
);
	import gqg_pkg::*;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic [8:0]         num;
		logic               ovf;
		logic               last;
	} vertex_t;

	vertex_t vertex_q[$];

	logic signed [31:0] glyph_mem[GLYPHS][8];
	logic signed [31:0] pen_x, pen_y;
	int unsigned        vert_count;
	logic               ovf_flag;
	logic [ATLAS_W_BITS-1:0] atlas_w, atlas_h;

	assign pending = vertex_q.size();

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// q16.16 multiply, round half up
	function automatic logic signed [31:0] scaled(input logic signed [31:0] a,
			input logic [30:0] s);
		longint q, r;
		q = longint'(a) * longint'({33'd0, s}) + 64'sd32768;
		if (q >= 0)
			r = q / 65536;
		else
			r = -((-q + 65535) / 65536);
		return clamp32(r);
	endfunction

	function automatic logic signed [31:0] tex_extent(input logic signed [31:0] size,
			input logic [ATLAS_W_BITS-1:0] div);
		longint d;
		d = (div == 0) ? 1 : longint'({51'd0, div});
		return clamp32(longint'(size) / d);
	endfunction

	// lay out one character and queue its vertex words
	task automatic layout_char();
		logic signed [31:0] g[8];
		logic signed [31:0] lft, tp, w, h, ax, ay, xl, xr, yt, yb, u1, v1;
		vertex_t vw;
		logic signed [31:0] px[6], py[6], pu[6], pv[6];
		if (first_char) begin
			pen_x = start_x;
			pen_y = start_y;
			vert_count = 0;
			ovf_flag = 1'b0;
		end
		for (int i = 0; i < 8; i++)
			g[i] = (code < GLYPHS) ? glyph_mem[code][i] : 32'sd0;
		lft = scaled(g[M_LEFT], scale_x);
		tp  = scaled(g[M_TOP], scale_y);
		w   = scaled(g[M_WIDTH], scale_x);
		h   = scaled(g[M_HEIGHT], scale_y);
		ax  = scaled(g[M_ADV_X], scale_x);
		ay  = scaled(g[M_ADV_Y], scale_y);
		xl = clamp32(longint'(pen_x) + longint'(lft));
		xr = clamp32(longint'(xl) + longint'(w));
		yt = clamp32(longint'(pen_y) + longint'(tp));
		yb = clamp32(longint'(yt) - longint'(h));
		pen_x = clamp32(longint'(pen_x) + longint'(ax));
		pen_y = clamp32(longint'(pen_y) + longint'(ay));
		if (w == 0 || h == 0)
			return;
		if (vert_count + 6 > VERT_LIMIT) begin
			ovf_flag = 1'b1;
			vw = '0;
			vw.num = vert_count[8:0];
			vw.ovf = 1'b1;
			vertex_q.push_back(vw);
			return;
		end
		u1 = clamp32(longint'(g[M_U]) + longint'(tex_extent(g[M_WIDTH], atlas_w)));
		v1 = clamp32(longint'(g[M_V]) + longint'(tex_extent(g[M_HEIGHT], atlas_h)));
		px = '{xl, xr, xl, xr, xl, xr};
		py = '{yt, yt, yb, yt, yb, yb};
		pu = '{g[M_U], u1, g[M_U], u1, g[M_U], u1};
		pv = '{g[M_V], g[M_V], v1, g[M_V], v1, v1};
		for (int k = 0; k < 6; k++) begin
			vert_count++;
			vw.x = px[k];
			vw.y = py[k];
			vw.z = start_z;
			vw.u = pu[k];
			vw.v = pv[k];
			vw.num = vert_count[8:0];
			vw.ovf = ovf_flag;
			vw.last = (k == 5);
			vertex_q.push_back(vw);
		end
	endtask

	// compare result words, then take in new words and register writes
	always @(posedge clk or negedge arst_n) begin
		vertex_t got, exp_w;
		if (!arst_n) begin
			pen_x = 0;
			pen_y = 0;
			vert_count = 0;
			ovf_flag = 1'b0;
			atlas_w = ATLAS_RESET;
			atlas_h = ATLAS_RESET;
			fail_count = 0;
			vertex_q.delete();
		end else begin
			if (result_valid) begin
				got = '{vert_x, vert_y, vert_z, tex_u, tex_v, vertex_number,
					overflow, last_of_quad};
				if (vertex_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word x=%h y=%h num=%0d",
							vert_x, vert_y, vertex_number);
				end else begin
					exp_w = vertex_q.pop_front();
					if (got !== exp_w) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch exp x=%h y=%h z=%h u=%h v=%h n=%0d o=%b l=%b",
								" got x=%h y=%h z=%h u=%h v=%h n=%0d o=%b l=%b"},
								exp_w.x, exp_w.y, exp_w.z, exp_w.u, exp_w.v, exp_w.num,
								exp_w.ovf, exp_w.last, got.x, got.y, got.z, got.u, got.v,
								got.num, got.ovf, got.last);
					end
				end
			end
			if (start && !busy) begin
				if (func == FUNC_WRITE) begin
					if (code < GLYPHS)
						glyph_mem[code][metric_select] = metric_value;
				end else
					layout_char();
			end
			if (wr_en) begin
				if (wr_index == REG_ATLAS_W)
					atlas_w = wr_data;
				else
					atlas_h = wr_data;
			end
		end
	end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import gqg_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 160;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic func = FUNC_WRITE;
	logic [7:0] code = '0;
	logic [2:0] metric_select = '0;
	logic signed [31:0] metric_value = '0;
	logic first_char = 1'b0;
	logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
	logic [30:0] scale_x = '0, scale_y = '0;
	logic wr_en = 1'b0;
	logic wr_index = REG_ATLAS_W;
	logic [ATLAS_W_BITS-1:0] wr_data = '0;
	logic result_valid;
	logic signed [31:0] vert_x, vert_y, vert_z, tex_u, tex_v;
	logic [8:0] vertex_number;
	logic overflow, last_of_quad;
	int fail_count, pending;
	int cycles = 0;
	int items = 0;

	logic [7:0] metric_mask[256];
	logic [7:0] ready_codes[$];

	always #4 clk = ~clk;

	glyph_quad_generator DUT (.*);

	quad_checker u_checker (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one word in: random gap, then hold until accepted
	task automatic send(input logic f, input logic [7:0] c, input logic [2:0] sel,
			input logic signed [31:0] mv, input logic fc, input logic signed [31:0] sx,
			input logic signed [31:0] sy, input logic signed [31:0] sz,
			input logic [30:0] kx, input logic [30:0] ky);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		code <= c;
		metric_select <= sel;
		metric_value <= mv;
		first_char <= fc;
		start_x <= sx;
		start_y <= sy;
		start_z <= sz;
		scale_x <= kx;
		scale_y <= ky;
		do @(posedge clk); while (busy);
		items++;
	endtask

	task automatic put_metric(input logic [7:0] c, input logic [2:0] sel,
			input logic signed [31:0] mv);
		send(FUNC_WRITE, c, sel, mv, 1'($urandom), $urandom, $urandom, $urandom,
			31'($urandom), 31'($urandom));
		metric_mask[c][sel] = 1'b1;
		if (metric_mask[c] == 8'hFF && !(c inside {ready_codes}))
			ready_codes.push_back(c);
	endtask

	function automatic logic signed [31:0] pick_metric(input logic [2:0] sel,
			input bit wild);
		if (wild)
			return $urandom;
		case (sel)
			M_LEFT, M_TOP: return $signed($urandom_range(0, 16 << 16)) - (8 << 16);
			M_WIDTH, M_HEIGHT:
				return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1 << 14, 32 << 16);
			M_ADV_X, M_ADV_Y: return $urandom_range(0, 40 << 16);
			default: return $urandom_range(0, 32'hFFFF);
		endcase
	endfunction

	task automatic load_glyph(input logic [7:0] c, input bit wild);
		for (int s = 0; s < 8; s++)
			put_metric(c, 3'(s), pick_metric(3'(s), wild));
	endtask

	function automatic logic [30:0] pick_scale();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r < 3)
			return 31'($urandom);
		return 31'($urandom_range(32'h8000, 32'h30000));
	endfunction

	task automatic put_char(input logic [7:0] c, input logic fc);
		logic signed [31:0] sx, sy;
		bit wide;
		wide = ($urandom_range(0, 4) == 0);
		sx = wide ? $urandom : $urandom_range(0, 640 << 16);
		sy = wide ? $urandom : $urandom_range(0, 480 << 16);
		send(FUNC_CHAR, c, 3'($urandom), $urandom, fc, sx, sy, $urandom, pick_scale(),
			pick_scale());
	endtask

	// one text: first character, then a run on the same pen
	task automatic put_text(input int len);
		for (int i = 0; i < len; i++)
			put_char(ready_codes[$urandom_range(0, ready_codes.size() - 1)], i == 0);
	endtask

	// wait for all words out plus the tail of a silent character
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_atlas(input logic [ATLAS_W_BITS-1:0] w,
			input logic [ATLAS_W_BITS-1:0] h);
		wr_en <= 1'b1;
		wr_index <= REG_ATLAS_W;
		wr_data <= w;
		@(posedge clk);
		wr_index <= REG_ATLAS_H;
		wr_data <= h;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		int r, stop_at;
		stop_at = items + count;
		while (items < stop_at) begin
			r = $urandom_range(0, 19);
			if (r < 2)
				load_glyph(8'($urandom), $urandom_range(0, 5) == 0);
			else if (r < 3)
				put_metric(8'($urandom), 3'($urandom),
					pick_metric(3'($urandom), 1'($urandom_range(0, 1))));
			else
				put_text(($urandom_range(0, 7) == 0) ? $urandom_range(40, 48)
					: $urandom_range(1, 12));
		end
	endtask

	initial begin
		logic [ATLAS_W_BITS-1:0] atlas_set[6][2];
		atlas_set = '{'{1, 1}, '{4096, 4096}, '{0, 0}, '{8191, 3}, '{17, 4095},
			'{13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096))}};
		for (int i = 0; i < 256; i++)
			metric_mask[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: a small glyph set with sane, extreme and empty metrics
		load_glyph(8'd0, 0);
		load_glyph(8'd255, 1);
		put_metric(8'd1, M_LEFT, 32'sh8000_0000);
		put_metric(8'd1, M_TOP, 32'sh7FFF_FFFF);
		put_metric(8'd1, M_WIDTH, 32'sh7FFF_FFFF);
		put_metric(8'd1, M_HEIGHT, 32'sh8000_0000);
		put_metric(8'd1, M_ADV_X, 32'sh7FFF_FFFF);
		put_metric(8'd1, M_ADV_Y, 32'sh8000_0000);
		put_metric(8'd1, M_U, 32'sh7FFF_FFFF);
		put_metric(8'd1, M_V, 32'sh8000_0000);
		send(FUNC_CHAR, 8'd0, M_LEFT, 0, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
			31'h10000, 31'h10000);
		send(FUNC_CHAR, 8'd1, M_LEFT, 0, 1'b0, 0, 0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
			31'h7FFF_FFFF);
		send(FUNC_CHAR, 8'd255, M_LEFT, 0, 1'b1, 0, 0, 32'sh8000_0000, 31'h10000,
			31'h10000);
		send(FUNC_CHAR, 8'd0, M_LEFT, 0, 1'b0, 0, 0, 0, 31'h0, 31'h10000);
		put_metric(8'd0, M_WIDTH, 0);
		send(FUNC_CHAR, 8'd0, M_LEFT, 0, 1'b0, 0, 0, 0, 31'h10000, 31'h10000);
		put_metric(8'd0, M_WIDTH, 32'sh0004_0000);
		put_metric(8'd255, M_LEFT, 32'sh0002_0000);
		drain();

		// random phases under several atlas settings, sender held off at each boundary
		foreach (atlas_set[p]) begin
			set_atlas(atlas_set[p][0], atlas_set[p][1]);
			if (p == 0) begin
				for (int g = 0; g < 8; g++)
					load_glyph(8'($urandom), 0);
				put_text(46);
			end
			random_phase(20);
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
